// ----- sv/tmr_pkg.sv -----
// ----------------------------------------------------------------------------
// tmr_pkg: shared types and constants for the tachometer median rpm core
// beat structures, configuration indexes, sequencer states and reset values
// ----------------------------------------------------------------------------
package tmr_pkg;

    localparam int unsigned DATA_W = 32;

    typedef struct packed {
        logic        action;
        logic [31:0] time_us;
    } tmr_in_t;

    typedef struct packed {
        logic [31:0] rpm_q4;
        logic [31:0] period_us;
        logic        from_median;
        logic        fresh;
        logic        stalled;
    } tmr_out_t;

    typedef enum logic [1:0] {
        CFG_DEBOUNCE  = 2'd0,
        CFG_TIMEOUT   = 2'd1,
        CFG_NUMERATOR = 2'd2,
        CFG_MIN_SAMP  = 2'd3
    } tmr_cfg_idx_t;

    localparam logic [15:0] DEBOUNCE_RST  = 16'd2000;
    localparam logic [23:0] TIMEOUT_RST   = 24'd500000;
    localparam logic [31:0] NUMERATOR_RST = 32'd1920000000;
    localparam logic [3:0]  MIN_SAMP_RST  = 4'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RANK,
        ST_PICK,
        ST_DIV,
        ST_OUT
    } tmr_state_t;

    // divider handshake
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } tmr_div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } tmr_div_rsp_t;

endpackage

// ----- sv/tmr_divider.sv -----
// ----------------------------------------------------------------------------
// tmr_divider: bit-serial restoring divider
// one quotient bit per cycle through a shifting remainder register
// ----------------------------------------------------------------------------
module tmr_divider (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  tmr_pkg::tmr_div_req_t req,
    output tmr_pkg::tmr_div_rsp_t rsp
);
    import tmr_pkg::*;

    logic [DATA_W-1:0] quot_reg, quot_next;
    logic [DATA_W-1:0] div_reg, div_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   diff;

    always_comb begin
        trial     = {rem_reg, quot_reg[DATA_W-1]};
        diff      = trial - {1'b0, div_reg};
        quot_next = quot_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            quot_next = req.dividend;
            div_next  = req.divisor;
            rem_next  = '0;
            cnt_next  = 6'(DATA_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // remainder stays below the divisor, so it fits the narrow register
            if (diff[DATA_W]) begin
                rem_next = trial[DATA_W-1:0];
                quot_next = {quot_reg[DATA_W-2:0], 1'b0};
            end else begin
                rem_next = diff[DATA_W-1:0];
                quot_next = {quot_reg[DATA_W-2:0], 1'b1};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quot_reg <= quot_next;
        div_reg  <= div_next;
        rem_reg  <= rem_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_reg;

endmodule

// ----- sv/tmr_median.sv -----
// ----------------------------------------------------------------------------
// tmr_median: period ring with a rank-counting median search
// each candidate is compared against every filled entry, one entry a cycle
// ----------------------------------------------------------------------------
module tmr_median #(
    parameter int unsigned WINDOW = 9
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        wr_en,
    input  logic [31:0] wr_data,
    input  logic        start,
    input  logic [$clog2(WINDOW+1)-1:0] count,
    output logic        done,
    output logic [31:0] median
);
    import tmr_pkg::*;

    localparam int unsigned IW = $clog2(WINDOW);
    localparam int unsigned CW = $clog2(WINDOW+1);

    logic [31:0]   ring [WINDOW];
    logic [IW-1:0] wslot_reg, wslot_next;
    logic [IW-1:0] cand_reg, cand_next;
    logic [IW-1:0] scan_reg, scan_next;
    logic [CW-1:0] less_reg, less_next;
    logic [CW-1:0] leq_reg, leq_next;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [31:0]   med_reg, med_next;
    logic [31:0]   cval;
    logic [31:0]   sval;
    logic [CW-1:0] half;
    logic [CW-1:0] less_f, leq_f;

    assign cval = ring[cand_reg];
    assign sval = ring[scan_reg];
    assign half = cnt_reg >> 1;

    always_comb begin
        wslot_next = wslot_reg;
        if (wr_en) begin
            wslot_next = (wslot_reg == IW'(WINDOW-1)) ? '0 : wslot_reg + IW'(1);
        end
        cand_next = cand_reg;
        scan_next = scan_reg;
        less_next = less_reg;
        leq_next  = leq_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        med_next  = med_reg;
        less_f    = less_reg + CW'(sval < cval);
        leq_f     = leq_reg + CW'(sval <= cval);
        if (start) begin
            cand_next = '0;
            scan_next = '0;
            less_next = '0;
            leq_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            less_next = less_f;
            leq_next  = leq_f;
            scan_next = scan_reg + IW'(1);
            if (CW'(scan_reg) == cnt_reg - CW'(1)) begin
                // candidate sits at sorted index half when less <= half < leq
                if (less_f <= half && half < leq_f) begin
                    med_next  = cval;
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
                cand_next = cand_reg + IW'(1);
                scan_next = '0;
                less_next = '0;
                leq_next  = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wslot_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            wslot_reg <= wslot_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
        if (start) begin
            cnt_reg <= count;
        end
        cand_reg <= cand_next;
        scan_reg <= scan_next;
        less_reg <= less_next;
        leq_reg  <= leq_next;
        med_reg  <= med_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ring[wslot_reg] <= wr_data;
        end
    end

    assign done   = done_reg;
    assign median = med_reg;

endmodule

// ----- sv/tachometer_median_rpm_core.sv -----
// ----------------------------------------------------------------------------
// tachometer_median_rpm_core: tach period meter with median filter
// debounces edges, forms two-interval periods, filters and divides to rpm
// ----------------------------------------------------------------------------
//  channel | direction | signals
//  s_      | in        | s_valid, s_ready, s_data (action, time_us)
//  m_      | out       | m_valid, m_ready, m_data (rpm_q4, period_us, flags)
//  cfg     | in        | cfg_we, cfg_index, cfg_wdata
//
//  time checks and rejected edges go straight to the result beat; a period with raw speed
//  passes through ST_PICK and ST_DIV, the bit-serial divider (one quotient bit a cycle)
//  the median adds ST_RANK, rank counting of each candidate against the filled entries
//  reset is synchronous and clears all control state, no clearing pass
//  one item at a time: s_ready is low from accept until the result beat leaves
// ----------------------------------------------------------------------------
module tachometer_median_rpm_core #(
    parameter int unsigned WINDOW = 9
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tmr_pkg::tmr_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output tmr_pkg::tmr_out_t m_data,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_wdata
);
    import tmr_pkg::*;

    localparam int unsigned CW = $clog2(WINDOW+1);

    logic [15:0] debounce_reg;
    logic [23:0] timeout_reg;
    logic [31:0] numer_reg;
    logic [3:0]  minsamp_reg;

    tmr_state_t  state_reg, state_next;
    logic [31:0] last_reg, last_next;
    logic [31:0] pair_reg, pair_next;
    logic        parity_reg, parity_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [31:0] speed_reg, speed_next;
    tmr_out_t    out_reg, out_next;
    logic [31:0] used_reg, used_next;

    logic [31:0] dt;
    logic [31:0] period;
    logic [CW-1:0] cnt_new;
    logic        wr_en;
    logic        med_start;
    logic        med_done;
    logic [31:0] med_val;
    tmr_div_req_t div_req;
    tmr_div_rsp_t div_rsp;

    assign dt     = s_data.time_us - last_reg;
    assign period = s_data.time_us - pair_reg;
    assign cnt_new = (fill_reg == CW'(WINDOW)) ? fill_reg : fill_reg + CW'(1);

    always_comb begin
        state_next  = state_reg;
        last_next   = last_reg;
        pair_next   = pair_reg;
        parity_next = parity_reg;
        fill_next   = fill_reg;
        speed_next  = speed_reg;
        out_next    = out_reg;
        used_next   = used_reg;
        wr_en       = 1'b0;
        med_start   = 1'b0;
        div_req     = '0;
        s_ready     = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    out_next   = '0;
                    state_next = ST_OUT;
                    if (!s_data.action) begin
                        if (dt > 32'(debounce_reg)) begin
                            last_next = s_data.time_us;
                            if (!parity_reg) begin
                                pair_next   = last_reg;
                                parity_next = 1'b1;
                            end else begin
                                parity_next       = 1'b0;
                                out_next.fresh    = 1'b1;
                                out_next.period_us = period;
                                if (period != '0) begin
                                    wr_en     = 1'b1;
                                    fill_next = cnt_new;
                                    used_next = period;
                                    if (32'(cnt_new) >= 32'(minsamp_reg)) begin
                                        out_next.from_median = 1'b1;
                                        med_start  = 1'b1;
                                        state_next = ST_RANK;
                                    end else begin
                                        state_next = ST_PICK;
                                    end
                                end
                            end
                        end
                    end else if (dt > 32'(timeout_reg)) begin
                        speed_next       = '0;
                        out_next.stalled = 1'b1;
                    end
                    out_next.rpm_q4 = speed_next;
                end
            end
            ST_RANK: begin
                if (med_done) begin
                    used_next  = med_val;
                    state_next = ST_PICK;
                end
            end
            ST_PICK: begin
                if (used_reg == '0) begin
                    state_next = ST_OUT;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.dividend = numer_reg;
                    div_req.divisor  = used_reg;
                    state_next       = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    speed_next      = div_rsp.quotient;
                    out_next.rpm_q4 = div_rsp.quotient;
                    state_next      = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_valid = (state_reg == ST_OUT);
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            last_reg     <= '0;
            pair_reg     <= '0;
            parity_reg   <= 1'b0;
            fill_reg     <= '0;
            speed_reg    <= '0;
            debounce_reg <= DEBOUNCE_RST;
            timeout_reg  <= TIMEOUT_RST;
            numer_reg    <= NUMERATOR_RST;
            minsamp_reg  <= MIN_SAMP_RST;
        end else begin
            state_reg  <= state_next;
            last_reg   <= last_next;
            pair_reg   <= pair_next;
            parity_reg <= parity_next;
            fill_reg   <= fill_next;
            speed_reg  <= speed_next;
            if (cfg_we) begin
                case (tmr_cfg_idx_t'(cfg_index))
                    CFG_DEBOUNCE:  debounce_reg <= cfg_wdata[15:0];
                    CFG_TIMEOUT:   timeout_reg  <= cfg_wdata[23:0];
                    CFG_NUMERATOR: numer_reg    <= cfg_wdata;
                    CFG_MIN_SAMP:  minsamp_reg  <= cfg_wdata[3:0];
                    default: ;
                endcase
            end
        end
        out_reg  <= out_next;
        used_reg <= used_next;
    end

    tmr_median #(.WINDOW(WINDOW)) u_median (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_en),
        .wr_data (period),
        .start   (med_start),
        .count   (cnt_new),
        .done    (med_done),
        .median  (med_val)
    );

    tmr_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

endmodule

// ----- sv/tmr_checker.sv -----
// ----------------------------------------------------------------------------
// tmr_checker: port-level checks for the tachometer median rpm core
// result flag consistency and one-at-a-time handshake behaviour
// ----------------------------------------------------------------------------
module tmr_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input tmr_pkg::tmr_in_t  s_data,
    input logic              m_valid,
    input logic              m_ready,
    input tmr_pkg::tmr_out_t m_data
);
    import tmr_pkg::*;

    // a stalled beat always reports zero speed
    a_stall_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.stalled |-> m_data.rpm_q4 == '0)
        else $error("stalled beat with nonzero rpm");

    // median flag only on a fresh period
    a_med_fresh: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.from_median |-> m_data.fresh && !m_data.stalled)
        else $error("median flag without fresh period");

    // no new beat taken while a result waits
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input taken while result pending");

    // result beat holds until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat dropped or changed");

    // offered input beat holds until taken
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input beat dropped or changed");

endmodule

bind tachometer_median_rpm_core tmr_checker u_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
